@@ src/power_button_sequencer_with_status_led_defines.svh @@
// ----------------------------------------------------------------------------
// Power button sequencer assertion macros
// Shared assertion forms, sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POWER_BUTTON_SEQUENCER_WITH_STATUS_LED_DEFINES_SVH
`define POWER_BUTTON_SEQUENCER_WITH_STATUS_LED_DEFINES_SVH

// same-cycle implication
`define PBS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PBS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/pbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Power button sequencer package
// Widths, register map, LED codes, color constants and the control types
// shared by the controller, the datapath and the divider.
// ----------------------------------------------------------------------------
package pbs_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam int NREG       = 8;
	localparam int IDX_W      = 3;

	localparam int IN_W       = 8;
	localparam int COLOR_W    = 8;
	localparam int OUT_USED   = 1 + 2 + 3 * COLOR_W + 1;
	localparam int OUT_W      = ((OUT_USED + 7) / 8) * 8;
	localparam int OUT_PAD    = OUT_W - OUT_USED;

	// breathing ramp
	localparam int BR_MIN     = 40;
	localparam int BR_MAX     = 80;
	localparam int BR_SPAN    = BR_MAX - BR_MIN;
	localparam int PCT_W      = 7;

	// shared divider
	localparam int DIV_W      = 22;
	localparam int DIV_CNT_W  = $clog2(DIV_W);

	// color scaling, x / 100 as (x * 5243) >> 19 for x below 2^15
	localparam int MUL_W       = 15;
	localparam int PROD_W      = 28;
	localparam int RECIP_100   = 5243;
	localparam int RECIP_SHIFT = 19;
	localparam int C_FULL      = 255;
	localparam int C_AMBER_G   = 140;
	localparam int C_SHUT_G    = 110;
	localparam logic [COLOR_W-1:0] C_WHITE = COLOR_W'((C_FULL * BR_MAX) / 100);

	typedef enum logic [IDX_W-1:0] {
		REG_DEBOUNCE,
		REG_LOCKOUT,
		REG_HOLD_ARM,
		REG_HOLD_OFF,
		REG_SIGNAL_LOSS,
		REG_BOOT_LED,
		REG_AP_HOLD,
		REG_BREATH_PERIOD
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] CFG_RESET [NREG] = '{
		16'd40, 16'd3000, 16'd3000, 16'd5000, 16'd10000, 16'd15000, 16'd15000, 16'd2500
	};

	typedef enum logic [1:0] {
		LED_OFF    = 2'd0,
		LED_BOOT   = 2'd1,
		LED_NORMAL = 2'd2,
		LED_SHUT   = 2'd3
	} led_mode_t;

	typedef struct packed {
		logic div_start;
		logic div_pct;
		logic mod_take;
		logic mul;
		logic scale;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

@@ src/pbs_div.sv @@
// ----------------------------------------------------------------------------
// Power button sequencer serial divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// breathing phase wrap and the breathing percent ramp.
// ----------------------------------------------------------------------------
module pbs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pbs_pkg::DIV_W-1:0]   dividend,
	input  logic [pbs_pkg::CFG_W-1:0]   divisor,
	output logic                        done,
	output logic [pbs_pkg::DIV_W-1:0]   quotient,
	output logic [pbs_pkg::CFG_W-1:0]   remainder
);
	import pbs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CFG_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [CFG_W-1:0]     dvs_q;

	logic [CFG_W:0]       trial;
	logic [CFG_W:0]       diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// divisor held for the whole pass
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ src/pbs_dp.sv @@
// ----------------------------------------------------------------------------
// Power button sequencer datapath
// Register file, tick update of debounce, power and LED state, breathing
// ramp through the shared divider, color scaling and the result register.
// ----------------------------------------------------------------------------
module pbs_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tick,
	input  logic                         button_raw,
	input  logic                         board_signal,
	input  logic                         cfg_valid,
	input  logic [pbs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [pbs_pkg::CFG_W-1:0]    cfg_data,
	input  pbs_pkg::dp_cmd_t             cmd,
	output pbs_pkg::dp_status_t          status,
	input  logic                         m_tready,
	output logic                         m_tvalid,
	output logic [pbs_pkg::OUT_W-1:0]    m_tdata
);
	import pbs_pkg::*;

	typedef struct packed {
		logic                  raw_last;
		logic                  button_stable;
		logic                  press_pend;
		logic                  release_pend;
		logic                  power_on;
		logic                  off_hold_run;
		logic                  loss_run;
		logic                  lockout_act;
		logic                  track_act;
		logic                  long_hold_done;
		led_mode_t             mode;
		logic [TIMER_BITS-1:0] debounce_cnt;
		logic [TIMER_BITS-1:0] on_elapsed;
		logic [TIMER_BITS-1:0] off_hold_cnt;
		logic [TIMER_BITS-1:0] loss_cnt;
		logic [TIMER_BITS-1:0] lockout_cnt;
		logic [TIMER_BITS-1:0] track_cnt;
		logic [TIMER_BITS-1:0] boot_cnt;
	} ctl_state_t;

	localparam ctl_state_t ST_RESET = '{
		raw_last:       1'b1,
		button_stable:  1'b1,
		press_pend:     1'b0,
		release_pend:   1'b0,
		power_on:       1'b0,
		off_hold_run:   1'b0,
		loss_run:       1'b0,
		lockout_act:    1'b0,
		track_act:      1'b0,
		long_hold_done: 1'b0,
		mode:           LED_OFF,
		debounce_cnt:   '0,
		on_elapsed:     '0,
		off_hold_cnt:   '0,
		loss_cnt:       '0,
		lockout_cnt:    '0,
		track_cnt:      '0,
		boot_cnt:       '0
	};

	function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic cnt_ge(input logic [TIMER_BITS-1:0] cnt,
	                                input logic [CFG_W-1:0] thr);
		return CMP_W'(cnt) >= CMP_W'(thr);
	endfunction

	function automatic ctl_state_t power_down(input ctl_state_t s);
		ctl_state_t r;
		r              = s;
		r.power_on     = 1'b0;
		r.on_elapsed   = '0;
		r.lockout_act  = 1'b1;
		r.lockout_cnt  = '0;
		r.press_pend   = 1'b0;
		r.release_pend = 1'b0;
		r.loss_run     = 1'b0;
		r.off_hold_run = 1'b0;
		r.mode         = LED_OFF;
		return r;
	endfunction

	function automatic ctl_state_t power_up(input ctl_state_t s);
		ctl_state_t r;
		r              = s;
		r.power_on     = 1'b1;
		r.on_elapsed   = '0;
		r.boot_cnt     = '0;
		r.mode         = LED_BOOT;
		r.loss_run     = 1'b0;
		r.off_hold_run = 1'b0;
		return r;
	endfunction

	function automatic logic [COLOR_W-1:0] div100(input logic [MUL_W-1:0] x);
		logic [PROD_W-1:0] p;
		p = PROD_W'(x) * PROD_W'(RECIP_100);
		return p[RECIP_SHIFT +: COLOR_W];
	endfunction

	logic [CFG_W-1:0]   cfg_q [NREG];
	ctl_state_t         st_q;
	ctl_state_t         nx;
	logic               ap_c;
	logic               start_c;
	logic               held_c;

	logic [CFG_W-1:0]   phase_q;
	logic [CFG_W-1:0]   ph_q;
	logic               res_drive_q;
	led_mode_t          res_mode_q;
	logic               res_ap_q;
	logic [MUL_W-1:0]   full_q;
	logic [MUL_W-1:0]   green_q;
	logic [COLOR_W-1:0] res_r_q;
	logic [COLOR_W-1:0] res_g_q;
	logic [COLOR_W-1:0] res_b_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_q;

	logic [CFG_W-1:0]   period;
	logic [CFG_W-1:0]   half;
	logic [CFG_W-1:0]   ph_c;
	logic [CFG_W:0]     ph_inc;
	logic [CFG_W-1:0]   ramp;
	logic [DIV_W-1:0]   num;
	logic [DIV_W-1:0]   div_dividend;
	logic [CFG_W-1:0]   div_divisor;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic [CFG_W-1:0]   div_rem;
	logic [PCT_W-1:0]   pct_c;
	logic               out_free;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// tick update
	always_comb begin
		nx      = st_q;
		ap_c    = 1'b0;
		start_c = 1'b0;

		if (nx.power_on)       nx.on_elapsed   = sat_inc(nx.on_elapsed);
		if (nx.off_hold_run)   nx.off_hold_cnt = sat_inc(nx.off_hold_cnt);
		if (nx.loss_run)       nx.loss_cnt     = sat_inc(nx.loss_cnt);
		if (nx.lockout_act)    nx.lockout_cnt  = sat_inc(nx.lockout_cnt);
		if (nx.track_act)      nx.track_cnt    = sat_inc(nx.track_cnt);
		if (nx.mode == LED_BOOT) nx.boot_cnt   = sat_inc(nx.boot_cnt);

		// debounce
		if (button_raw != nx.raw_last) begin
			nx.raw_last     = button_raw;
			nx.debounce_cnt = '0;
		end else begin
			nx.debounce_cnt = sat_inc(nx.debounce_cnt);
		end
		if (cnt_ge(nx.debounce_cnt, cfg_q[REG_DEBOUNCE]) && (nx.button_stable != button_raw)) begin
			nx.button_stable = button_raw;
			if (!button_raw) begin
				nx.press_pend = 1'b1;
			end else begin
				nx.release_pend = 1'b1;
			end
		end
		held_c = !nx.button_stable;

		// power on path
		if (!nx.power_on) begin
			if (nx.press_pend) begin
				nx.press_pend     = 1'b0;
				nx.track_act      = 1'b1;
				nx.track_cnt      = '0;
				nx.long_hold_done = 1'b0;
			end
			if (nx.track_act && !nx.long_hold_done && held_c &&
			    cnt_ge(nx.track_cnt, cfg_q[REG_AP_HOLD])) begin
				ap_c              = 1'b1;
				nx.long_hold_done = 1'b1;
			end
			if (nx.release_pend) begin
				nx.release_pend = 1'b0;
				if (nx.track_act) begin
					start_c = !cnt_ge(nx.track_cnt, cfg_q[REG_AP_HOLD]) && !nx.long_hold_done;
					nx.track_act      = 1'b0;
					nx.long_hold_done = 1'b0;
				end
			end
			if (nx.lockout_act) begin
				if (cnt_ge(nx.lockout_cnt, cfg_q[REG_LOCKOUT])) begin
					nx.lockout_act = 1'b0;
				end else begin
					start_c = 1'b0;
				end
			end
			if (!nx.lockout_act && start_c) begin
				nx = power_up(nx);
			end
		end

		// power off path
		if (nx.power_on) begin
			if (cnt_ge(nx.on_elapsed, cfg_q[REG_HOLD_ARM])) begin
				if (held_c) begin
					if (!nx.off_hold_run) begin
						nx.off_hold_run = 1'b1;
						nx.off_hold_cnt = '0;
					end else if (cnt_ge(nx.off_hold_cnt, cfg_q[REG_HOLD_OFF])) begin
						nx = power_down(nx);
					end
				end else begin
					nx.off_hold_run = 1'b0;
				end
			end else begin
				nx.off_hold_run = 1'b0;
			end
			if (nx.power_on) begin
				if (board_signal) begin
					nx.loss_run = 1'b0;
				end else if (!nx.loss_run) begin
					nx.loss_run = 1'b1;
					nx.loss_cnt = '0;
				end else if (cnt_ge(nx.loss_cnt, cfg_q[REG_SIGNAL_LOSS])) begin
					nx = power_down(nx);
				end
			end
		end

		// led mode
		if (!nx.power_on) begin
			nx.mode = LED_OFF;
		end else begin
			if (nx.mode == LED_OFF) begin
				nx.mode     = LED_BOOT;
				nx.boot_cnt = '0;
			end
			if (nx.mode == LED_BOOT) begin
				if (!board_signal) begin
					nx.mode = LED_SHUT;
				end else if (cnt_ge(nx.boot_cnt, cfg_q[REG_BOOT_LED])) begin
					nx.mode = LED_NORMAL;
				end
			end else if (nx.mode == LED_NORMAL) begin
				if (!board_signal) nx.mode = LED_SHUT;
			end else if (board_signal) begin
				nx.mode = LED_NORMAL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (tick) begin
			st_q <= nx;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			res_drive_q <= nx.power_on;
			res_mode_q  <= nx.mode;
			res_ap_q    <= ap_c;
		end
	end

	// breathing phase and ramp
	assign period = cfg_q[REG_BREATH_PERIOD];
	assign half   = {1'b0, period[CFG_W-1:1]};
	assign ph_c   = (period == '0) ? '0 : div_rem;
	assign ph_inc = {1'b0, ph_c} + (CFG_W+1)'(1);
	assign ramp   = (ph_q <= half) ? ph_q : period - ph_q;
	assign num    = DIV_W'(ramp) * DIV_W'(BR_SPAN);

	assign div_dividend = cmd.div_pct ? num : DIV_W'(phase_q);
	assign div_divisor  = cmd.div_pct ? half : period;

	pbs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cmd.mod_take) begin
			phase_q <= (ph_inc >= {1'b0, period}) ? '0 : ph_inc[CFG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_take) begin
			ph_q <= ph_c;
		end
	end

	// color scaling
	assign pct_c = (half == '0) ? PCT_W'(BR_MIN) : PCT_W'(BR_MIN) + div_quo[PCT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			full_q  <= MUL_W'(pct_c) * MUL_W'(C_FULL);
			green_q <= MUL_W'(pct_c) *
			           ((res_mode_q == LED_BOOT) ? MUL_W'(C_AMBER_G) : MUL_W'(C_SHUT_G));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			unique case (res_mode_q)
				LED_OFF: begin
					res_r_q <= '0;
					res_g_q <= '0;
					res_b_q <= '0;
				end
				LED_BOOT: begin
					res_r_q <= div100(full_q);
					res_g_q <= div100(green_q);
					res_b_q <= '0;
				end
				LED_NORMAL: begin
					res_r_q <= C_WHITE;
					res_g_q <= C_WHITE;
					res_b_q <= C_WHITE;
				end
				LED_SHUT: begin
					res_r_q <= '0;
					res_g_q <= div100(green_q);
					res_b_q <= div100(full_q);
				end
			endcase
		end
	end

	// result register
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && out_free) begin
			out_q <= {{OUT_PAD{1'b0}}, res_ap_q, res_b_q, res_g_q, res_r_q, res_mode_q,
			          res_drive_q};
		end
	end

	assign status.div_done = div_done;
	assign status.out_free = out_free;
	assign m_tvalid        = out_valid_q;
	assign m_tdata         = out_q;

endmodule

@@ src/pbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// Power button sequencer controller
// Sequences one item through tick update, phase wrap, ramp division,
// color scaling and the result register.
// ----------------------------------------------------------------------------
module pbs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pbs_pkg::dp_status_t   status,
	output pbs_pkg::dp_cmd_t      cmd
);
	import pbs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD_GO,
		S_MOD_WAIT,
		S_MOD_TAKE,
		S_PCT_GO,
		S_PCT_WAIT,
		S_MUL,
		S_SCALE,
		S_LOAD
	} state_t;

	state_t   state_q;
	logic     ready_q;
	dp_cmd_t  cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
			cmd_q   <= '0;
		end else begin
			cmd_q <= '0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q         <= S_MOD_GO;
						ready_q         <= 1'b0;
						cmd_q.div_start <= 1'b1;
					end
				end
				S_MOD_GO: begin
					state_q <= S_MOD_WAIT;
				end
				S_MOD_WAIT: begin
					if (status.div_done) begin
						state_q        <= S_MOD_TAKE;
						cmd_q.mod_take <= 1'b1;
					end
				end
				S_MOD_TAKE: begin
					state_q         <= S_PCT_GO;
					cmd_q.div_start <= 1'b1;
					cmd_q.div_pct   <= 1'b1;
				end
				S_PCT_GO: begin
					state_q <= S_PCT_WAIT;
				end
				S_PCT_WAIT: begin
					if (status.div_done) begin
						state_q   <= S_MUL;
						cmd_q.mul <= 1'b1;
					end
				end
				S_MUL: begin
					state_q     <= S_SCALE;
					cmd_q.scale <= 1'b1;
				end
				S_SCALE: begin
					state_q    <= S_LOAD;
					cmd_q.load <= 1'b1;
				end
				S_LOAD: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end else begin
						cmd_q.load <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = ready_q;
	assign cmd      = cmd_q;

endmodule

@@ src/power_button_sequencer_with_status_led.sv @@
// ----------------------------------------------------------------------------
// Power button sequencer with status LED
// One item per 1 ms tick: debounced button, power drive sequencing with
// lockout and hold timers, access point request and breathing status LED.
//
//   channel  signals                      item
//   s_*      s_tvalid s_tready s_tdata    tick input
//   m_*      m_tvalid m_tready m_tdata    drive, LED and request result
//   cfg_*    cfg_valid cfg_ready          register write
//            cfg_index cfg_data
//
// Each item runs through two passes of the shared radix-2 divider over
// the 22-bit dividend (phase wrap, ramp) plus the command steps around
// them before the next item is accepted.
// A finished result waits in the output register; the next item is taken
// while it waits and stalls only before its own result would overwrite it.
// Reset loads the register defaults and the released, powered-off state.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module power_button_sequencer_with_status_led (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [0] button_raw, [1] board_signal
	input  logic [pbs_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [0] drive_on, [2:1] led_mode, [10:3] led_red, [18:11] led_green,
	// [26:19] led_blue, [27] ap_request
	output logic [pbs_pkg::OUT_W-1:0]    m_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pbs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [pbs_pkg::CFG_W-1:0]    cfg_data
);
	import pbs_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       tick;

	assign tick      = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	pbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pbs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (tick),
		.button_raw   (s_tdata[0]),
		.board_signal (s_tdata[1]),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.m_tdata      (m_tdata)
	);

endmodule

@@ src/pbs_chk.sv @@
// ----------------------------------------------------------------------------
// Power button sequencer port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "power_button_sequencer_with_status_led_defines.svh"

module pbs_chk (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [pbs_pkg::OUT_W-1:0]    m_tdata
);
	import pbs_pkg::*;

	`PBS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	`PBS_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken back to back")

	`PBS_ASSERT_IMP(a_off_dark, m_tvalid && !m_tdata[0], m_tdata[26:1] == '0, "LED lit while drive off")

	`PBS_ASSERT_IMP(a_on_mode, m_tvalid && m_tdata[0], m_tdata[2:1] != LED_OFF, "LED mode off while drive on")

	`PBS_ASSERT_IMP(a_white, m_tvalid && (m_tdata[2:1] == LED_NORMAL), (m_tdata[10:3] == C_WHITE) && (m_tdata[18:11] == C_WHITE) && (m_tdata[26:19] == C_WHITE), "normal mode not white")

endmodule

bind power_button_sequencer_with_status_led pbs_chk u_pbs_chk (.*);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Power button sequencer regression bench
// Sends 1 ms tick items (raw button level, board signal) and compares every
// result item with a cycle-free tick model kept inside the bench, or with the
// row's own result for a typed directed row. A short directed table comes
// first, then random button and signal episodes under several register
// settings with sender gaps, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pbs_pkg::*;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES = 800;
	localparam int PRESSURE_PLAN = 2;
	localparam int NPLANS = 9;
	localparam int NDIRECTED = 24;
	localparam logic [3:0] NO_PLAN = 4'hF;
	localparam logic [3:0] PLAN_SHORT = 4'd0;

	typedef struct packed {
		logic                 ap;
		logic [COLOR_W-1:0]   blue;
		logic [COLOR_W-1:0]   green;
		logic [COLOR_W-1:0]   red;
		led_mode_t            mode;
		logic                 drive;
	} tick_result_t;

	typedef struct packed {
		logic [3:0]   plan;
		logic         raw;
		logic         sig;
		logic         typed;
		tick_result_t want;
	} step_row_t;

	localparam tick_result_t OFF_RES = '{
		ap: 1'b0, blue: 8'd0, green: 8'd0, red: 8'd0, mode: LED_OFF, drive: 1'b0
	};

	// debounce, lockout, hold_arm, hold_off, signal_loss, boot_led, ap_hold, breath_period
	localparam logic [CFG_W-1:0] REG_PLANS [NPLANS][NREG] = '{
		'{16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd2, 16'd3, 16'd2},
		'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd2, 16'd5, 16'd3, 16'd4, 16'd6, 16'd8, 16'd12, 16'd7},
		'{16'd1, 16'd0, 16'd0, 16'd2, 16'd3, 16'd4, 16'd20, 16'd1},
		'{16'd3, 16'd10, 16'd5, 16'd6, 16'd10, 16'd15, 16'd8, 16'd16},
		'{16'd0, 16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535},
		'{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
			16'd65535},
		'{16'd5, 16'd30, 16'd20, 16'd25, 16'd30, 16'd40, 16'd50, 16'd2500},
		'{16'd1, 16'd4, 16'd2, 16'd3, 16'd5, 16'd6, 16'd9, 16'd3}
	};

	localparam int PLAN_ITEMS [NPLANS] = '{0, 100, 260, 260, 260, 120, 80, 260, 260};
	localparam int SEND_IDLE_PCT [4] = '{0, 81, 0, 22};
	localparam int RECV_STALL_PCT [4] = '{0, 0, 81, 22};

	localparam step_row_t DIRECTED_STEPS [NDIRECTED] = '{
		'{NO_PLAN, 1'b1, 1'b1, 1'b1, OFF_RES},
		'{NO_PLAN, 1'b0, 1'b0, 1'b1, OFF_RES},
		'{NO_PLAN, 1'b0, 1'b1, 1'b1, OFF_RES},
		'{NO_PLAN, 1'b1, 1'b0, 1'b1, OFF_RES},
		// short thresholds from here on
		'{PLAN_SHORT, 1'b1, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b0, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b1, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b1, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b1, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b1, 1'b0, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b1, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b1, 1'b0, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b1, 1'b0, 1'b0, OFF_RES},
		// long hold while off
		'{NO_PLAN, 1'b0, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b0, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b0, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b0, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b0, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b1, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b0, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b1, 1'b1, 1'b0, OFF_RES},
		// hold to off, press edge dropped
		'{NO_PLAN, 1'b0, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b0, 1'b1, 1'b0, OFF_RES},
		'{NO_PLAN, 1'b1, 1'b1, 1'b0, OFF_RES}
	};

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	// tick model state
	logic [CFG_W-1:0]       reg_val [NREG];
	logic                   raw_prev, btn_lvl, press_pend, release_pend;
	logic                   pwr_on, offhold_run, loss_run, lock_run, press_run, ap_sent;
	led_mode_t              led_state;
	logic [TIMER_BITS-1:0]  bounce_cnt, on_ticks, offhold_ticks, loss_ticks;
	logic [TIMER_BITS-1:0]  lock_ticks, press_ticks, boot_ticks;
	logic [CFG_W-1:0]       breath_pos;

	tick_result_t  expected_q [$];
	int            send_idle;
	int            recv_stall;
	int            hold_left;
	int            fail_count;
	int            ticks_sent;
	int            results_seen;
	int            power_ups;
	int            power_downs;
	int            ap_pulses;
	int unsigned   cycle_count = 0;

	power_button_sequencer_with_status_led u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("power_button_sequencer_with_status_led regression: fail");
			$finish;
		end
	end

	function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic void switch_off();
		pwr_on = 1'b0;
		on_ticks = '0;
		lock_run = 1'b1;
		lock_ticks = '0;
		press_pend = 1'b0;
		release_pend = 1'b0;
		loss_run = 1'b0;
		offhold_run = 1'b0;
		led_state = LED_OFF;
		power_downs++;
	endfunction

	task automatic reset_model();
		reg_val = CFG_RESET;
		raw_prev = 1'b1;
		btn_lvl = 1'b1;
		press_pend = 1'b0;
		release_pend = 1'b0;
		pwr_on = 1'b0;
		offhold_run = 1'b0;
		loss_run = 1'b0;
		lock_run = 1'b0;
		press_run = 1'b0;
		ap_sent = 1'b0;
		led_state = LED_OFF;
		bounce_cnt = '0;
		on_ticks = '0;
		offhold_ticks = '0;
		loss_ticks = '0;
		lock_ticks = '0;
		press_ticks = '0;
		boot_ticks = '0;
		breath_pos = '0;
	endtask

	task automatic predict_tick(input logic raw, input logic sig, output tick_result_t res);
		logic held, go;
		int per, half, ph, ramp, pct, nxt;
		res = '0;
		if (pwr_on) on_ticks = bump(on_ticks);
		if (offhold_run) offhold_ticks = bump(offhold_ticks);
		if (loss_run) loss_ticks = bump(loss_ticks);
		if (lock_run) lock_ticks = bump(lock_ticks);
		if (press_run) press_ticks = bump(press_ticks);
		if (led_state == LED_BOOT) boot_ticks = bump(boot_ticks);

		// debounce
		if (raw != raw_prev) begin
			raw_prev = raw;
			bounce_cnt = '0;
		end else begin
			bounce_cnt = bump(bounce_cnt);
		end
		if (bounce_cnt >= reg_val[REG_DEBOUNCE] && btn_lvl != raw) begin
			btn_lvl = raw;
			if (!raw) press_pend = 1'b1;
			else release_pend = 1'b1;
		end
		held = !btn_lvl;

		if (!pwr_on) begin
			if (press_pend) begin
				press_pend = 1'b0;
				press_run = 1'b1;
				press_ticks = '0;
				ap_sent = 1'b0;
			end
			if (press_run && !ap_sent && held && press_ticks >= reg_val[REG_AP_HOLD]) begin
				res.ap = 1'b1;
				ap_sent = 1'b1;
				ap_pulses++;
			end
			go = 1'b0;
			if (release_pend) begin
				release_pend = 1'b0;
				if (press_run) begin
					go = (press_ticks < reg_val[REG_AP_HOLD]) && !ap_sent;
					press_run = 1'b0;
					ap_sent = 1'b0;
				end
			end
			if (lock_run) begin
				if (lock_ticks >= reg_val[REG_LOCKOUT]) lock_run = 1'b0;
				else go = 1'b0;
			end
			if (!lock_run && go) begin
				pwr_on = 1'b1;
				on_ticks = '0;
				boot_ticks = '0;
				led_state = LED_BOOT;
				loss_run = 1'b0;
				offhold_run = 1'b0;
				power_ups++;
			end
		end

		if (pwr_on) begin
			if (on_ticks >= reg_val[REG_HOLD_ARM] && held) begin
				if (!offhold_run) begin
					offhold_run = 1'b1;
					offhold_ticks = '0;
				end else if (offhold_ticks >= reg_val[REG_HOLD_OFF]) begin
					switch_off();
				end
			end else begin
				offhold_run = 1'b0;
			end
			if (pwr_on) begin
				if (sig) begin
					loss_run = 1'b0;
				end else if (!loss_run) begin
					loss_run = 1'b1;
					loss_ticks = '0;
				end else if (loss_ticks >= reg_val[REG_SIGNAL_LOSS]) begin
					switch_off();
				end
			end
		end

		// led mode
		if (!pwr_on) begin
			led_state = LED_OFF;
		end else begin
			if (led_state == LED_OFF) begin
				led_state = LED_BOOT;
				boot_ticks = '0;
			end
			case (led_state)
				LED_BOOT: begin
					if (!sig) led_state = LED_SHUT;
					else if (boot_ticks >= reg_val[REG_BOOT_LED]) led_state = LED_NORMAL;
				end
				LED_NORMAL: begin
					if (!sig) led_state = LED_SHUT;
				end
				default: begin
					if (sig) led_state = LED_NORMAL;
				end
			endcase
		end

		// breathing triangle between the low and high percent
		per = int'(reg_val[REG_BREATH_PERIOD]);
		half = per / 2;
		if (half == 0) begin
			pct = BR_MIN;
		end else begin
			ph = int'(breath_pos) % per;
			ramp = (ph <= half) ? ph : per - ph;
			pct = BR_MIN + (BR_MAX - BR_MIN) * ramp / half;
		end
		case (led_state)
			LED_NORMAL: begin
				res.red = C_WHITE;
				res.green = C_WHITE;
				res.blue = C_WHITE;
			end
			LED_BOOT: begin
				res.red = COLOR_W'(C_FULL * pct / 100);
				res.green = COLOR_W'(C_AMBER_G * pct / 100);
			end
			LED_SHUT: begin
				res.green = COLOR_W'(C_SHUT_G * pct / 100);
				res.blue = COLOR_W'(C_FULL * pct / 100);
			end
			default: ;
		endcase

		if (per == 0) begin
			breath_pos = '0;
		end else begin
			nxt = int'(breath_pos) % per + 1;
			breath_pos = (nxt >= per) ? '0 : CFG_W'(nxt);
		end

		res.drive = pwr_on;
		res.mode = led_state;
	endtask

	task automatic send_tick(input logic raw, input logic sig, input logic typed = 1'b0,
			input tick_result_t want = '0);
		tick_result_t res;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({sig, raw});
		do @(posedge clk); while (!s_tready);
		predict_tick(raw, sig, res);
		expected_q.push_back(typed ? want : res);
		ticks_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input int plan);
		for (int i = 0; i < NREG; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= REG_PLANS[plan][i];
			do @(posedge clk); while (!cfg_ready);
			reg_val[i] = REG_PLANS[plan][i];
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic mostly_present();
		return 1'($urandom_range(99) >= 5);
	endfunction

	task automatic play_episode(input int span);
		int kind;
		kind = $urandom_range(99);
		if (kind < 60) begin
			// bouncy contact before a clean press
			if (kind >= 45)
				repeat ($urandom_range(6, 1)) send_tick(1'($urandom_range(1)), 1'b1);
			repeat ($urandom_range(span, 1)) send_tick(1'b0, mostly_present());
			repeat ($urandom_range(span, 1)) send_tick(1'b1, mostly_present());
		end else if (kind < 80) begin
			repeat ($urandom_range(span, 1)) send_tick(1'b1, 1'b0);
			repeat ($urandom_range(span / 2 + 1, 1)) send_tick(1'b1, 1'b1);
		end else begin
			repeat ($urandom_range(10, 1))
				send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
		end
	endtask

	task automatic check_result(input logic [OUT_W-1:0] data);
		tick_result_t act, exp_res;
		logic bad;
		act = tick_result_t'(data[$bits(tick_result_t)-1:0]);
		results_seen++;
		if (expected_q.size() == 0) begin
			$error("result item with nothing expected: %h", data);
			fail_count++;
		end else begin
			exp_res = expected_q.pop_front();
			bad = 1'b0;
			if (act.drive !== exp_res.drive) begin
				$error("drive_on: expected %0d, got %0d", exp_res.drive, act.drive);
				bad = 1'b1;
			end
			if (act.mode !== exp_res.mode) begin
				$error("led_mode: expected %0d, got %0d", exp_res.mode, act.mode);
				bad = 1'b1;
			end
			if (act.red !== exp_res.red) begin
				$error("led_red: expected %0d, got %0d", exp_res.red, act.red);
				bad = 1'b1;
			end
			if (act.green !== exp_res.green) begin
				$error("led_green: expected %0d, got %0d", exp_res.green, act.green);
				bad = 1'b1;
			end
			if (act.blue !== exp_res.blue) begin
				$error("led_blue: expected %0d, got %0d", exp_res.blue, act.blue);
				bad = 1'b1;
			end
			if (act.ap !== exp_res.ap) begin
				$error("ap_request: expected %0d, got %0d", exp_res.ap, act.ap);
				bad = 1'b1;
			end
			if (bad) fail_count++;
		end
	endtask

	// result side
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) check_result(m_tdata);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	initial begin
		int span, mx, target;
		step_row_t row;
		send_idle = 0;
		recv_stall = 0;
		hold_left = 0;
		fail_count = 0;
		ticks_sent = 0;
		results_seen = 0;
		power_ups = 0;
		power_downs = 0;
		ap_pulses = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_DEBOUNCE;
		cfg_data <= '0;
		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = SEND_IDLE_PCT[3];
		recv_stall = RECV_STALL_PCT[3];
		for (int i = 0; i < NDIRECTED; i++) begin
			row = DIRECTED_STEPS[i];
			if (row.plan != NO_PLAN) begin
				drain_results();
				program_regs(int'(row.plan));
			end
			send_tick(row.raw, row.sig, row.typed, row.want);
		end

		for (int p = 1; p < NPLANS; p++) begin
			drain_results();
			program_regs(p);
			send_idle = SEND_IDLE_PCT[p % 4];
			recv_stall = RECV_STALL_PCT[p % 4];
			if (p == PRESSURE_PLAN) hold_left = HOLD_CYCLES;
			mx = 0;
			for (int r = 0; r < NREG; r++) begin
				if (cfg_reg_t'(r) != REG_LOCKOUT && cfg_reg_t'(r) != REG_HOLD_ARM &&
						cfg_reg_t'(r) != REG_BREATH_PERIOD && int'(REG_PLANS[p][r]) > mx)
					mx = int'(REG_PLANS[p][r]);
			end
			span = (mx > 56) ? 60 : mx + 4;
			target = ticks_sent + PLAN_ITEMS[p];
			while (ticks_sent < target) play_episode(span);
		end
		drain_results();

		$display("%0d tick items under %0d register settings, %0d results compared",
			ticks_sent, NPLANS, results_seen);
		$display("%0d power-ups, %0d power-downs, %0d access point requests predicted",
			power_ups, power_downs, ap_pulses);
		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("power_button_sequencer_with_status_led regression: pass");
		end else begin
			$display("power_button_sequencer_with_status_led regression: fail");
		end
		$finish;
	end

endmodule
